// ===== rtl/core/rational_arithmetic_unit_top_assert.svh =====
// Assertion macros shared by the RTL
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_ASSERT_SVH

// check cons in the same cycle as ante
`define RAU_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// check cons in the cycle after ante
`define RAU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rau_pkg.sv =====
`timescale 1ns / 1ps
package rau_pkg;

  localparam int OPW    = 16;
  localparam int PW     = 2 * OPW;
  localparam int NUM_W  = 34;
  localparam int DEN_W  = 33;
  localparam int CNT_W  = $clog2(PW);

  localparam logic [1:0] MODE_ADD = 2'd0;
  localparam logic [1:0] MODE_SUB = 2'd1;
  localparam logic [1:0] MODE_MUL = 2'd2;
  localparam logic [1:0] MODE_DIV = 2'd3;

  typedef struct packed {
    logic [1:0]            mode;
    logic signed [OPW-1:0] a_numerator;
    logic signed [OPW-1:0] a_denominator;
    logic signed [OPW-1:0] b_numerator;
    logic signed [OPW-1:0] b_denominator;
  } in_word_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] result_numerator;
    logic [DEN_W-1:0]        result_denominator;
    logic                    result_valid;
  } out_word_t;

  typedef struct packed {
    logic           invalid;
    logic           combine;
    logic           neg1;
    logic           neg2;
    logic [OPW-1:0] m1a;
    logic [OPW-1:0] m1b;
    logic [OPW-1:0] m2a;
    logic [OPW-1:0] m2b;
    logic [OPW-1:0] mda;
    logic [OPW-1:0] mdb;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } qhead_t;

endpackage

// ===== rtl/core/rau_front.sv =====
`timescale 1ns / 1ps
module rau_front
  import rau_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  in_word_t in_word,
  output logic     busy,
  output qhead_t   q_head,
  input  logic     pop
);

  job_t       slot_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  job_t       job_new;

  logic           an_s, ad_s, bn_s, bd_s;
  logic [OPW-1:0] an_m, ad_m, bn_m, bd_m;
  logic           an_neg, bn_neg, bn_eff;

  function automatic logic [OPW-1:0] mag_of(input logic [OPW-1:0] v);
    mag_of = v[OPW-1] ? (~v + 1'b1) : v;
  endfunction

  always_comb begin
    an_s = in_word.a_numerator[OPW-1];
    ad_s = in_word.a_denominator[OPW-1];
    bn_s = in_word.b_numerator[OPW-1];
    bd_s = in_word.b_denominator[OPW-1];
    an_m = mag_of(in_word.a_numerator);
    ad_m = mag_of(in_word.a_denominator);
    bn_m = mag_of(in_word.b_numerator);
    bd_m = mag_of(in_word.b_denominator);
    an_neg = (an_s ^ ad_s) && (an_m != '0);
    bn_neg = (bn_s ^ bd_s) && (bn_m != '0);
    bn_eff = (in_word.mode == MODE_SUB) ? (!bn_neg && (bn_m != '0)) : bn_neg;

    job_new = '0;
    job_new.invalid = (ad_m == '0) || (bd_m == '0) ||
                      ((in_word.mode == MODE_DIV) && (bn_m == '0));
    unique case (in_word.mode)
      MODE_ADD, MODE_SUB: begin
        job_new.combine = 1'b1;
        job_new.neg1 = an_neg;
        job_new.neg2 = bn_eff;
        job_new.m1a = an_m;
        job_new.m1b = bd_m;
        job_new.m2a = bn_m;
        job_new.m2b = ad_m;
        job_new.mda = ad_m;
        job_new.mdb = bd_m;
      end
      MODE_MUL: begin
        job_new.neg1 = an_neg ^ bn_neg;
        job_new.m1a = an_m;
        job_new.m1b = bn_m;
        job_new.mda = ad_m;
        job_new.mdb = bd_m;
      end
      default: begin
        job_new.neg1 = an_neg ^ bn_neg;
        job_new.m1a = an_m;
        job_new.m1b = bd_m;
        job_new.mda = ad_m;
        job_new.mdb = bn_m;
      end
    endcase
  end

  assign busy         = (cnt_r == 2'd2);
  assign push         = start && !busy;
  assign q_head.valid = (cnt_r != 2'd0);
  assign q_head.job   = slot_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop && q_head.valid) begin
      rp_nxt = ~rp_r;
    end
    cnt_nxt = cnt_r + 2'(push) - 2'(pop && q_head.valid);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= job_new;
    end
  end

endmodule

// ===== rtl/core/rau_back.sv =====
`timescale 1ns / 1ps
module rau_back
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  qhead_t    q_head,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_word
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_MUL  = 6'b000010,
    ST_SUM  = 6'b000100,
    ST_GCD  = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  state_t         state_r, state_nxt;
  job_t           job_r, job_nxt;
  logic [1:0]     mcnt_r, mcnt_nxt;
  logic [PW-1:0]  p1_r, p1_nxt, p2_r, p2_nxt, pd_r, pd_nxt;
  logic           nneg_r, nneg_nxt;
  logic [PW-1:0]  nmag_r, nmag_nxt;
  logic [PW-1:0]  gx_r, gx_nxt, gy_r, gy_nxt, g_r, g_nxt;
  logic [CNT_W-1:0] gk_r, gk_nxt, dcnt_r, dcnt_nxt;
  logic [PW:0]    remn_r, remn_nxt, remd_r, remd_nxt;
  logic [PW-1:0]  quon_r, quon_nxt, quod_r, quod_nxt;
  logic           out_valid_r, out_valid_nxt;
  out_word_t      out_word_r, out_word_nxt;

  logic [OPW-1:0] ma, mb;
  logic [PW-1:0]  prod;
  logic [PW:0]    tn, td;

  always_comb begin
    unique case (mcnt_r)
      2'd0:    begin ma = job_r.m1a; mb = job_r.m1b; end
      2'd1:    begin ma = job_r.m2a; mb = job_r.m2b; end
      default: begin ma = job_r.mda; mb = job_r.mdb; end
    endcase
    prod = {{OPW{1'b0}}, ma} * {{OPW{1'b0}}, mb};
    tn   = {remn_r[PW-1:0], quon_r[PW-1]};
    td   = {remd_r[PW-1:0], quod_r[PW-1]};
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    mcnt_nxt      = mcnt_r;
    p1_nxt        = p1_r;
    p2_nxt        = p2_r;
    pd_nxt        = pd_r;
    nneg_nxt      = nneg_r;
    nmag_nxt      = nmag_r;
    gx_nxt        = gx_r;
    gy_nxt        = gy_r;
    gk_nxt        = gk_r;
    g_nxt         = g_r;
    dcnt_nxt      = dcnt_r;
    remn_nxt      = remn_r;
    remd_nxt      = remd_r;
    quon_nxt      = quon_r;
    quod_nxt      = quod_r;
    out_valid_nxt = 1'b0;
    out_word_nxt  = out_word_r;
    pop           = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_head.valid) begin
          pop      = 1'b1;
          job_nxt  = q_head.job;
          mcnt_nxt = 2'd0;
          state_nxt = q_head.job.invalid ? ST_OUT : ST_MUL;
        end
      end
      ST_MUL: begin
        unique case (mcnt_r)
          2'd0:    p1_nxt = prod;
          2'd1:    p2_nxt = prod;
          default: pd_nxt = prod;
        endcase
        mcnt_nxt = mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) begin
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        priority if (!job_r.combine) begin
          nmag_nxt = p1_r;
          nneg_nxt = job_r.neg1;
        end else if (job_r.neg1 == job_r.neg2) begin
          nmag_nxt = p1_r + p2_r;
          nneg_nxt = job_r.neg1;
        end else if (p1_r >= p2_r) begin
          nmag_nxt = p1_r - p2_r;
          nneg_nxt = job_r.neg1;
        end else begin
          nmag_nxt = p2_r - p1_r;
          nneg_nxt = job_r.neg2;
        end
        gx_nxt    = nmag_nxt;
        gy_nxt    = pd_r;
        gk_nxt    = '0;
        state_nxt = ST_GCD;
      end
      ST_GCD: begin
        priority if (gx_r == '0) begin
          g_nxt     = gy_r << gk_r;
          dcnt_nxt  = '0;
          remn_nxt  = '0;
          remd_nxt  = '0;
          quon_nxt  = nmag_r;
          quod_nxt  = pd_r;
          state_nxt = ST_DIV;
        end else if (!gx_r[0] && !gy_r[0]) begin
          gx_nxt = gx_r >> 1;
          gy_nxt = gy_r >> 1;
          gk_nxt = gk_r + 1'b1;
        end else if (!gx_r[0]) begin
          gx_nxt = gx_r >> 1;
        end else if (!gy_r[0]) begin
          gy_nxt = gy_r >> 1;
        end else if (gx_r >= gy_r) begin
          gx_nxt = gx_r - gy_r;
        end else begin
          gy_nxt = gy_r - gx_r;
        end
      end
      ST_DIV: begin
        if (tn >= {1'b0, g_r}) begin
          remn_nxt = tn - {1'b0, g_r};
          quon_nxt = {quon_r[PW-2:0], 1'b1};
        end else begin
          remn_nxt = tn;
          quon_nxt = {quon_r[PW-2:0], 1'b0};
        end
        if (td >= {1'b0, g_r}) begin
          remd_nxt = td - {1'b0, g_r};
          quod_nxt = {quod_r[PW-2:0], 1'b1};
        end else begin
          remd_nxt = td;
          quod_nxt = {quod_r[PW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == CNT_W'(PW - 1)) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_valid_nxt = 1'b1;
        if (job_r.invalid) begin
          out_word_nxt = '0;
        end else begin
          out_word_nxt.result_numerator = nneg_r ?
            -$signed({{(NUM_W-PW){1'b0}}, quon_r}) :
            $signed({{(NUM_W-PW){1'b0}}, quon_r});
          out_word_nxt.result_denominator = {{(DEN_W-PW){1'b0}}, quod_r};
          out_word_nxt.result_valid       = 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    mcnt_r     <= mcnt_nxt;
    p1_r       <= p1_nxt;
    p2_r       <= p2_nxt;
    pd_r       <= pd_nxt;
    nneg_r     <= nneg_nxt;
    nmag_r     <= nmag_nxt;
    gx_r       <= gx_nxt;
    gy_r       <= gy_nxt;
    gk_r       <= gk_nxt;
    g_r        <= g_nxt;
    dcnt_r     <= dcnt_nxt;
    remn_r     <= remn_nxt;
    remd_r     <= remd_nxt;
    quon_r     <= quon_nxt;
    quod_r     <= quod_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

// ===== rtl/core/rational_arithmetic_unit_top.sv =====
// Steps: an invalid word goes from the pop straight to the output state; a valid word takes
// a pop, 3 multiply steps, 1 sum step, binary gcd steps, 32 divide steps and the output state.
// Flow: the shared gcd/divide sequencer takes no new word until it is back in idle after
// the output state, for invalid and valid words alike; a two-entry queue lets start
// be taken while the sequencer works. The receiver cannot stall.
// Reset: synchronous active-low rst_n empties the queue and idles the sequencer.
`timescale 1ns / 1ps
module rational_arithmetic_unit_top
  import rau_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_word_t  in_word,
  output logic      busy,
  output logic      out_valid,
  output out_word_t out_word
);

  qhead_t q_head;
  logic   pop;

  rau_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_word (in_word),
    .busy    (busy),
    .q_head  (q_head),
    .pop     (pop)
  );

  rau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

`include "rational_arithmetic_unit_top_assert.svh"

  `RAU_ASSERT_SAME(a_invalid_zero, out_valid && !out_word.result_valid,
    out_word.result_numerator == '0 && out_word.result_denominator == '0, "invalid not zero")
  `RAU_ASSERT_SAME(a_den_nonzero, out_valid && out_word.result_valid,
    out_word.result_denominator != '0, "valid with zero denominator")
  `RAU_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "back-to-back strobes")

endmodule
